[rtl/open_addressing_hash_table_core_defines.svh]
// Assertion macros shared by the hash table RTL.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define OAHT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define OAHT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[rtl/oaht_pkg.sv]
// Shared types and codes for the open-addressed hash table.
// No dependencies; used by open_addressing_hash_table_core.
`default_nettype none

package oaht_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key_hash;
        logic [DATA_W-1:0] value_in;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   value_out;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/oaht_ram.sv]
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
`default_nettype none

module oaht_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

[rtl/open_addressing_hash_table_core.sv]
// Open-addressed hash table core with triangular probing.
// Depends on oaht_pkg, oaht_ram and open_addressing_hash_table_core_defines.svh.
`default_nettype none
`include "open_addressing_hash_table_core_defines.svh"

// Usage
//   Command beat: drive i_cmd and raise start; the beat is taken at a clock
//   edge where start is high and busy is low. For a known op code busy stays
//   high until the operation has finished.
//   Result beat: o_done is high for exactly one cycle with o_rsp valid. The
//   receiver cannot stall, so it must capture o_rsp in that cycle.
//   Sequence (power-of-two TABLE_DEPTH): the home slot is read as the
//   command is taken, then the probed slots are checked in turn, up to
//   PROBE_LIMIT of them, and the result is registered. Other depths
//   first run the home-slot reduction (reciprocal multiply, then one
//   correction step). Unused op codes answer on the next cycle.
//   Throughput: one command at a time; a new command can be taken in the
//   cycle o_done is high. The probe loop on the single table port sets the
//   rate: one slot read per cycle, with the insert/remove write landing in
//   the cycle the matching slot is checked.
//   Reset: synchronous, active low. After reset a clearing pass writes every
//   table entry empty, with busy high.

module open_addressing_hash_table_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PROBE_LIMIT = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  oaht_pkg::t_cmd      i_cmd,
    output logic                busy,
    output logic                o_done,
    output oaht_pkg::t_rsp      o_rsp
);

    // Table geometry
    localparam int IW      = $clog2(TABLE_DEPTH);       // slot index width
    localparam int CW      = $clog2(TABLE_DEPTH + 1);   // occupancy count width
    localparam int JW      = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int KW      = oaht_pkg::KEY_W;
    localparam int DW      = oaht_pkg::DATA_W;
    localparam int SW      = oaht_pkg::SLOT_W;
    localparam int NW      = oaht_pkg::COUNT_W;
    localparam int MW      = 1 + KW + VALUE_WIDTH;      // {occupied, key, value}
    localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

    localparam logic [IW:0]   DEPTH_X   = (IW+1)'(TABLE_DEPTH);
    localparam logic [IW-1:0] DEPTH_M1  = IW'(TABLE_DEPTH - 1);
    localparam logic [JW-1:0] PROBE_END = JW'(PROBE_LIMIT - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(TABLE_DEPTH);

    // Reciprocal of the depth for the home-slot reduction
    localparam int          PW      = 2 * KW + 1;       // key times reciprocal
    localparam int          QW      = KW + 1 - IW;      // quotient estimate width
    localparam logic [63:0] RECIP_X = (64'd1 << (KW + IW)) / 64'(TABLE_DEPTH);
    localparam logic [KW:0] RECIP   = RECIP_X[KW:0];

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset sweep
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;  // key times reciprocal
    localparam logic [2:0] S_READ  = 3'd3;  // finish home slot, read it
    localparam logic [2:0] S_CHECK = 3'd4;  // check slot, issue next read

    // Control registers
    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_clr,   n_clr;
    logic [CW-1:0] r_count, n_count;
    logic [JW-1:0] r_j,     n_j;
    logic          r_done,  n_done;

    // Per-command payload registers
    logic [oaht_pkg::OP_W-1:0]     r_op,     n_op;
    logic [KW-1:0]                 r_key,    n_key;
    logic [DW-1:0]                 r_val,    n_val;
    logic [PW-1:0]                 r_prod,   n_prod;
    logic [IW-1:0]                 r_b,      n_b;    // slot being probed
    logic [IW-1:0]                 r_jn,     n_jn;   // next offset step mod depth
    logic [oaht_pkg::STATUS_W-1:0] r_status, n_status;
    logic [DW-1:0]                 r_vout,   n_vout;
    logic [IW-1:0]                 r_slot,   n_slot;

    // Table memory port
    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [MW-1:0] ram_wdata;
    logic [MW-1:0] ram_rdata;

    oaht_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Read word fields
    logic                   rd_occ;
    logic [KW-1:0]          rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;
    assign rd_occ = ram_rdata[MW-1];
    assign rd_key = ram_rdata[MW-2 -: KW];
    assign rd_val = ram_rdata[VALUE_WIDTH-1:0];

    // Width adaption between the 32-bit ports and the stored value
    logic [VALUE_WIDTH+DW-1:0] val_in_ext;
    logic [VALUE_WIDTH+DW-1:0] val_out_ext;
    logic [VALUE_WIDTH-1:0]    val_st;
    logic [DW-1:0]             val_rd;
    assign val_in_ext  = {{VALUE_WIDTH{1'b0}}, r_val};
    assign val_st      = val_in_ext[VALUE_WIDTH-1:0];
    assign val_out_ext = {{DW{1'b0}}, rd_val};
    assign val_rd      = val_out_ext[DW-1:0];

    // Home slot for other depths: (key * RECIP) >> (KW + IW) is at most one
    // below key / depth, so one compare and subtract finishes key mod depth
    logic [PW-1:0]   prod;
    logic [QW-1:0]   q_est;
    logic [KW+1:0]   qd;
    logic [KW+1:0]   rem_raw;
    logic [IW:0]     rem_fix;
    logic [IW-1:0]   home_mod;
    assign prod    = {{(KW+1){1'b0}}, r_key} * {{KW{1'b0}}, RECIP};
    assign q_est   = r_prod[PW-1 -: QW];
    assign qd      = {{(IW+1){1'b0}}, q_est} * {{QW{1'b0}}, DEPTH_X};
    assign rem_raw = {2'b00, r_key} - qd;
    always_comb begin
        rem_fix = rem_raw[IW:0];
        if (rem_fix >= DEPTH_X) begin
            rem_fix = rem_fix - DEPTH_X;
        end
        home_mod = rem_fix[IW-1:0];
    end

    // Next probe slot: b + step, step already below depth
    logic [IW:0]   b_sum;
    logic [IW-1:0] b_next;
    logic [IW-1:0] jn_next;
    always_comb begin
        b_sum = {1'b0, r_b} + {1'b0, r_jn};
        if (b_sum >= DEPTH_X) begin
            b_sum = b_sum - DEPTH_X;
        end
        b_next  = b_sum[IW-1:0];
        jn_next = (r_jn == DEPTH_M1) ? '0 : r_jn + IW'(1);
    end

    // Slot check
    logic is_ins, is_rem, is_lkp, hit, last_probe, cmd_known;
    assign is_ins     = (r_op == oaht_pkg::OP_INSERT);
    assign is_rem     = (r_op == oaht_pkg::OP_REMOVE);
    assign is_lkp     = (r_op == oaht_pkg::OP_LOOKUP);
    assign hit        = is_ins ? !rd_occ : (rd_occ && (rd_key == r_key));
    assign last_probe = (r_j == PROBE_END);
    assign cmd_known  = (i_cmd.op == oaht_pkg::OP_INSERT) ||
                        (i_cmd.op == oaht_pkg::OP_REMOVE) ||
                        (i_cmd.op == oaht_pkg::OP_LOOKUP);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_count  = r_count;
        n_j      = r_j;
        n_done   = 1'b0;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_prod   = r_prod;
        n_b      = r_b;
        n_jn     = r_jn;
        n_status = r_status;
        n_vout   = r_vout;
        n_slot   = r_slot;
        ram_we    = 1'b0;
        ram_addr  = r_b;
        ram_wdata = {1'b1, r_key, val_st};

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + IW'(1);
                if (r_clr == DEPTH_M1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.op;
                    n_key  = i_cmd.key_hash;
                    n_val  = i_cmd.value_in;
                    n_j    = '0;
                    n_jn   = IW'(1);
                    if (!cmd_known) begin
                        // unused op code: no table access, answer at once
                        n_done   = 1'b1;
                        n_status = oaht_pkg::ST_MISSING;
                        n_vout   = i_cmd.value_in;
                        n_slot   = '0;
                    end else if (IS_POW2) begin
                        ram_addr = i_cmd.key_hash[IW-1:0];
                        n_b      = i_cmd.key_hash[IW-1:0];
                        n_state  = S_CHECK;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_prod  = prod;
                n_state = S_READ;
            end
            S_READ: begin
                ram_addr = home_mod;
                n_b      = home_mod;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (hit) begin
                    n_done   = 1'b1;
                    n_status = oaht_pkg::ST_OK;
                    n_slot   = r_b;
                    n_vout   = is_lkp ? val_rd : r_val;
                    n_state  = S_IDLE;
                    if (is_ins) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    if (is_rem) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, rd_key, rd_val};
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end else if (last_probe) begin
                    n_done   = 1'b1;
                    n_status = is_ins ? oaht_pkg::ST_FULL : oaht_pkg::ST_MISSING;
                    n_slot   = '0;
                    n_vout   = r_val;
                    n_state  = S_IDLE;
                end else begin
                    // miss: read the next slot on the path in this cycle
                    ram_addr = b_next;
                    n_b      = b_next;
                    n_jn     = jn_next;
                    n_j      = r_j + JW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_j     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_j     <= n_j;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_prod   <= n_prod;
        r_b      <= n_b;
        r_jn     <= n_jn;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_slot   <= n_slot;
    end

    // Outputs; entry_count is the count after the finished command
    logic [SW+IW-1:0] slot_ext;
    logic [NW+CW-1:0] count_ext;
    assign slot_ext  = {{SW{1'b0}}, r_slot};
    assign count_ext = {{NW{1'b0}}, r_count};

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = '{status:      r_status,
                      value_out:   r_vout,
                      slot:        slot_ext[SW-1:0],
                      entry_count: count_ext[NW-1:0]};

    // Assertions
    `OAHT_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!o_done && busy), "reset must clear done and start the sweep")
    `OAHT_ASSERT(a_count_bound, r_count <= COUNT_MAX, "occupancy count exceeds table depth")
    `OAHT_ASSERT(a_write_state, ram_we |-> (r_state == S_CLEAR || r_state == S_CHECK), "table write outside sweep or check")
    `OAHT_ASSERT(a_cmd_busy, (start && !busy && cmd_known) |=> (busy && !o_done), "known command did not hold busy")
    `OAHT_ASSERT(a_full_insert, (o_done && o_rsp.status == oaht_pkg::ST_FULL) |-> is_ins, "full status on a non-insert")

endmodule

`default_nettype wire
